### rtl/sem_pkg.sv
`timescale 1ns / 1ps

package sem_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GRADIENT_MODE = 2'd2;

	localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_WIDTH  = 12'd640;
	localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;
	localparam logic [CFG_DATA_W-1:0] MIN_DIM            = 12'd3;

	localparam logic [7:0] EDGE_MAX = 8'd255;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_X    = 2'd1,
		MODE_Y    = 2'd2,
		MODE_AVG  = 2'd3
	} sem_mode_t;

	// Neighborhood in raster order; the center pixel does not enter either kernel.
	typedef struct packed {
		logic [7:0] p1;
		logic [7:0] p2;
		logic [7:0] p3;
		logic [7:0] p4;
		logic [7:0] p6;
		logic [7:0] p7;
		logic [7:0] p8;
		logic [7:0] p9;
	} sem_window_t;

endpackage

### rtl/sem_ram.sv
`timescale 1ns / 1ps

module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/sem_grad.sv
`timescale 1ns / 1ps

module sem_grad import sem_pkg::*; (
	input  sem_window_t win,
	input  sem_mode_t   mode,
	output logic [7:0]  edge_value
);

	logic [9:0]         gx_pos;
	logic [9:0]         gx_neg;
	logic [9:0]         gy_pos;
	logic [9:0]         gy_neg;
	logic signed [10:0] gx;
	logic signed [10:0] gy;
	logic [9:0]         ax;
	logic [9:0]         ay;
	logic [10:0]        sum;
	logic [9:0]         g;

	always_comb begin
		gx_pos = 10'(win.p3) + {1'b0, win.p6, 1'b0} + 10'(win.p9);
		gx_neg = 10'(win.p1) + {1'b0, win.p4, 1'b0} + 10'(win.p7);
		gy_pos = 10'(win.p7) + {1'b0, win.p8, 1'b0} + 10'(win.p9);
		gy_neg = 10'(win.p1) + {1'b0, win.p2, 1'b0} + 10'(win.p3);
		gx = signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
		gy = signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});
		ax = gx[10] ? 10'(-gx) : gx[9:0];
		ay = gy[10] ? 10'(-gy) : gy[9:0];
		sum = {1'b0, ax} + {1'b0, ay};
		case (mode)
			MODE_X: begin
				g = ax;
			end
			MODE_Y: begin
				g = ay;
			end
			MODE_AVG: begin
				g = sum[10:1];
			end
			default: begin
				g = '0;
			end
		endcase
		edge_value = (g[9:8] != 2'b00) ? EDGE_MAX : g[7:0];
	end

endmodule

### rtl/sobel_edge_magnitude_3x3.sv
`timescale 1ns / 1ps
// Channel | Valid       | Stall       | Payload
// pixel   | pixel_valid | pixel_stall | pixel_value
// edge    | edge_valid  | edge_stall  | edge_value, center_row, center_col, last_in_frame
//
// One pixel is taken every cycle while pixel_stall is low; its result passes the stage-one
// registers and the line store read issued at acceptance, then lands in the result register.
// Reset clears the counters, window and valid flags; line store contents stay undefined.
// A stalled result holds the stage behind it, so pixel_stall follows edge_stall.
// Border pixels update the line stores and window but yield no item.

module sobel_edge_magnitude_3x3 import sem_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	input  logic                   pixel_valid,
	output logic                   pixel_stall,
	input  logic [7:0]             pixel_value,
	output logic                   edge_valid,
	input  logic                   edge_stall,
	output logic [7:0]             edge_value,
	output logic [10:0]            center_row,
	output logic [10:0]            center_col,
	output logic                   last_in_frame
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CFG_DATA_W-1:0] image_width_q;
	logic [CFG_DATA_W-1:0] image_height_q;
	sem_mode_t             gradient_mode_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] w_last;
	logic [RW-1:0] h_last;

	logic          accept;
	logic          s1_move;

	logic          valid_s1;
	logic          produce_s1;
	logic          last_s1;
	logic [7:0]    pixel_s1;
	logic [CW-1:0] col_s1;
	logic [10:0]   row_out_s1;
	logic [10:0]   col_out_s1;

	logic [7:0]    top_rd;
	logic [7:0]    mid_rd;
	logic [7:0]    win_q [6];

	sem_window_t   win;
	logic [7:0]    grad;

	logic          edge_valid_q;

	always_comb begin
		if (image_width_q < MIN_DIM) begin
			w_last = CW'(2);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(image_width_q - 12'd1);
		end
		if (image_height_q < MIN_DIM) begin
			h_last = RW'(2);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			h_last = RW'(MAX_HEIGHT - 1);
		end else begin
			h_last = RW'(image_height_q - 12'd1);
		end
	end

	assign s1_move     = valid_s1 && (!edge_valid_q || !edge_stall);
	assign pixel_stall = valid_s1 && !s1_move;
	assign accept      = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= RESET_IMAGE_WIDTH;
			image_height_q  <= RESET_IMAGE_HEIGHT;
			gradient_mode_q <= MODE_AVG;
			col_q           <= '0;
			row_q           <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH: begin
					image_width_q <= wr_data;
					col_q         <= '0;
					row_q         <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= wr_data;
					col_q          <= '0;
					row_q          <= '0;
				end
				REG_GRADIENT_MODE: begin
					gradient_mode_q <= sem_mode_t'(wr_data[1:0]);
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (col_q == w_last) begin
				col_q <= '0;
				row_q <= (row_q == h_last) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1   <= pixel_value;
			col_s1     <= col_q;
			produce_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			last_s1    <= (row_q == h_last) && (col_q == w_last);
			row_out_s1 <= 11'(row_q - RW'(1));
			col_out_s1 <= 11'(col_q - CW'(1));
		end
	end

	sem_ram #(
		.WIDTH(8),
		.DEPTH(MAX_WIDTH)
	) u_upper (
		.clk  (clk),
		.we   (s1_move),
		.waddr(col_s1),
		.wdata(mid_rd),
		.re   (accept),
		.raddr(col_q),
		.rdata(top_rd)
	);

	sem_ram #(
		.WIDTH(8),
		.DEPTH(MAX_WIDTH)
	) u_lower (
		.clk  (clk),
		.we   (s1_move),
		.waddr(col_s1),
		.wdata(pixel_s1),
		.re   (accept),
		.raddr(col_q),
		.rdata(mid_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_move) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_rd;
			win_q[4] <= mid_rd;
			win_q[5] <= pixel_s1;
		end
	end

	always_comb begin
		win.p1 = win_q[0];
		win.p4 = win_q[1];
		win.p7 = win_q[2];
		win.p2 = win_q[3];
		win.p8 = win_q[5];
		win.p3 = top_rd;
		win.p6 = mid_rd;
		win.p9 = pixel_s1;
	end

	sem_grad u_grad (
		.win       (win),
		.mode      (gradient_mode_q),
		.edge_value(grad)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_valid_q <= 1'b0;
		end else if (s1_move) begin
			edge_valid_q <= produce_s1;
		end else if (!edge_stall) begin
			edge_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && produce_s1) begin
			edge_value    <= grad;
			center_row    <= row_out_s1;
			center_col    <= col_out_s1;
			last_in_frame <= last_s1;
		end
	end

	assign edge_valid = edge_valid_q;

endmodule

### tb/sobel_edge_magnitude_3x3_checker.sv
`timescale 1ns / 1ps

module sobel_edge_magnitude_3x3_checker import sem_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	input  logic                   pixel_valid,
	input  logic                   pixel_stall,
	input  logic [7:0]             pixel_value,
	input  logic                   edge_valid,
	input  logic                   edge_stall,
	input  logic [7:0]             edge_value,
	input  logic [10:0]            center_row,
	input  logic [10:0]            center_col,
	input  logic                   last_in_frame,
	output int                     failures,
	output int                     pending_results
);

	localparam int DIM_MAX = 2048;

	typedef struct packed {
		logic [7:0]  magnitude;
		logic [10:0] row;
		logic [10:0] col;
		logic        last;
	} edge_item_t;

	edge_item_t expected_edges[$];
	edge_item_t oldest;
	logic [7:0] upper_row [DIM_MAX];
	logic [7:0] lower_row [DIM_MAX];
	logic [7:0] far_col [3];
	logic [7:0] near_col [3];
	logic [11:0] col_pos;
	logic [11:0] row_pos;
	logic [CFG_DATA_W-1:0] cfg_width;
	logic [CFG_DATA_W-1:0] cfg_height;
	sem_mode_t cfg_mode;

	function automatic logic [11:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
		if (v < MIN_DIM) return MIN_DIM;
		if (v > DIM_MAX) return 12'(DIM_MAX);
		return v;
	endfunction

	task automatic check_field(input string field, input logic [10:0] want,
			input logic [10:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			failures++;
		end
	endtask

	task automatic predict_edge(input logic [7:0] pix);
		logic [11:0] w;
		logic [11:0] h;
		logic [11:0] c;
		logic [11:0] r;
		logic [7:0] top;
		logic [7:0] mid;
		int gx;
		int gy;
		int g;
		edge_item_t item;
		w = clamp_dim(cfg_width);
		h = clamp_dim(cfg_height);
		c = (col_pos >= w) ? 12'd0 : col_pos;
		r = (row_pos >= h) ? 12'd0 : row_pos;
		top = upper_row[c];
		mid = lower_row[c];
		if (r >= 2 && c >= 2) begin
			gx = -int'(far_col[0]) + int'(top) - 2 * int'(far_col[1]) + 2 * int'(mid)
				- int'(far_col[2]) + int'(pix);
			gy = -int'(far_col[0]) - 2 * int'(near_col[0]) - int'(top) + int'(far_col[2])
				+ 2 * int'(near_col[2]) + int'(pix);
			if (gx < 0) gx = -gx;
			if (gy < 0) gy = -gy;
			case (cfg_mode)
				MODE_X:   g = gx;
				MODE_Y:   g = gy;
				MODE_AVG: g = (gx + gy) / 2;
				default:  g = 0;
			endcase
			if (g > int'(EDGE_MAX)) g = int'(EDGE_MAX);
			item.magnitude = g[7:0];
			item.row = 11'(r - 12'd1);
			item.col = 11'(c - 12'd1);
			item.last = (r == h - 12'd1) && (c == w - 12'd1);
			expected_edges.push_back(item);
		end
		upper_row[c] = mid;
		lower_row[c] = pix;
		far_col = near_col;
		near_col[0] = top;
		near_col[1] = mid;
		near_col[2] = pix;
		c = c + 12'd1;
		if (c >= w) begin
			c = 12'd0;
			r = r + 12'd1;
			if (r >= h) r = 12'd0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_edges.delete();
			for (int i = 0; i < DIM_MAX; i++) begin
				upper_row[i] = 8'd0;
				lower_row[i] = 8'd0;
			end
			for (int i = 0; i < 3; i++) begin
				far_col[i] = 8'd0;
				near_col[i] = 8'd0;
			end
			col_pos = 12'd0;
			row_pos = 12'd0;
			cfg_width = RESET_IMAGE_WIDTH;
			cfg_height = RESET_IMAGE_HEIGHT;
			cfg_mode = MODE_AVG;
			failures = 0;
			pending_results <= 0;
		end else begin
			if (edge_valid && !edge_stall) begin
				if (expected_edges.size() == 0) begin
					$error("edge item with no result expected: edge_value %0d row %0d col %0d",
						edge_value, center_row, center_col);
					failures++;
				end else begin
					oldest = expected_edges.pop_front();
					check_field("edge_value", oldest.magnitude, edge_value);
					check_field("center_row", oldest.row, center_row);
					check_field("center_col", oldest.col, center_col);
					check_field("last_in_frame", oldest.last, last_in_frame);
				end
			end
			if (pixel_valid && !pixel_stall) predict_edge(pixel_value);
			if (wr_en) begin
				case (wr_index)
					REG_IMAGE_WIDTH: begin
						cfg_width = wr_data;
						col_pos = 12'd0;
						row_pos = 12'd0;
					end
					REG_IMAGE_HEIGHT: begin
						cfg_height = wr_data;
						col_pos = 12'd0;
						row_pos = 12'd0;
					end
					REG_GRADIENT_MODE: begin
						cfg_mode = sem_mode_t'(wr_data[1:0]);
					end
					default: begin
					end
				endcase
			end
			pending_results <= expected_edges.size();
		end
	end

endmodule

### tb/sobel_edge_magnitude_3x3_test.sv
`timescale 1ns / 1ps

module sobel_edge_magnitude_3x3_test import sem_pkg::*; ();

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_PIXELS  = 240;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DIM_MAX        = 2048;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0]  wr_data = '0;
	logic                   pixel_valid = 1'b0;
	logic                   pixel_stall;
	logic [7:0]             pixel_value = '0;
	logic                   edge_valid;
	logic                   edge_stall = 1'b0;
	logic [7:0]             edge_value;
	logic [10:0]            center_row;
	logic [10:0]            center_col;
	logic                   last_in_frame;

	int failures;
	int pending_results;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	logic hold_go = 1'b0;
	int hold_left = 0;
	int stuck_cycles = 0;
	int eff_width = 640;
	int eff_height = 480;

	// Three-column frame: Y mode saturates, then average and none run.
	logic [7:0] directed_pixels [18] = '{
		8'd0,   8'd0,   8'd255,
		8'd0,   8'd0,   8'd255,
		8'd0,   8'd0,   8'd255,
		8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd0,
		8'd1,   8'd2,   8'd3
	};
	sem_mode_t directed_modes [3] = '{MODE_Y, MODE_AVG, MODE_NONE};

	always #5 clk = ~clk;

	sobel_edge_magnitude_3x3 DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_value  (pixel_value),
		.edge_valid   (edge_valid),
		.edge_stall   (edge_stall),
		.edge_value   (edge_value),
		.center_row   (center_row),
		.center_col   (center_col),
		.last_in_frame(last_in_frame)
	);

	sobel_edge_magnitude_3x3_checker edge_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.pixel_valid    (pixel_valid),
		.pixel_stall    (pixel_stall),
		.pixel_value    (pixel_value),
		.edge_valid     (edge_valid),
		.edge_stall     (edge_stall),
		.edge_value     (edge_value),
		.center_row     (center_row),
		.center_col     (center_col),
		.last_in_frame  (last_in_frame),
		.failures       (failures),
		.pending_results(pending_results)
	);

	always @(posedge clk) begin
		if (hold_left != 0) begin
			edge_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go) begin
			edge_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			edge_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (edge_valid && !edge_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [7:0] random_pixel();
		case ($urandom_range(7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_value <= value;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
	endtask

	task automatic set_mode(input sem_mode_t mode);
		write_reg(REG_GRADIENT_MODE, CFG_DATA_W'(mode));
		wr_en <= 1'b0;
	endtask

	task automatic configure(input int w, input int h, input sem_mode_t mode);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_GRADIENT_MODE, CFG_DATA_W'(mode));
		wr_en <= 1'b0;
		eff_width = (w < 3) ? 3 : ((w > DIM_MAX) ? DIM_MAX : w);
		eff_height = (h < 3) ? 3 : ((h > DIM_MAX) ? DIM_MAX : h);
	endtask

	initial begin
		int sent;
		int n;
		int w_raw;
		int h_raw;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: two full rows and a little of the third.
		repeat (2 * 640 + 8) send_pixel(random_pixel());
		wait_drained();

		write_reg(REG_UNUSED, 12'hFFF);
		configure(3, 6, MODE_X);
		for (int i = 0; i < 18; i++) begin
			if (i >= 9 && i % 3 == 0) begin
				wait_drained();
				set_mode(directed_modes[i / 3 - 3]);
			end
			send_pixel(directed_pixels[i]);
		end
		wait_drained();

		// The receiver holds off while the sender keeps offering items.
		configure(8, 8, MODE_AVG);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		repeat (64) send_pixel(random_pixel());
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct <= 0;
				end
				1: begin
					sender_idle_pct = 80;
					receiver_stall_pct <= 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct <= 80;
				end
				default: begin
					sender_idle_pct = 32;
					receiver_stall_pct <= 32;
				end
			endcase
			sent = 0;
			while (sent < RANDOM_PIXELS / 4) begin
				wait_drained();
				if ($urandom_range(3) != 0) begin
					w_raw = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
					h_raw = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
					configure(w_raw, h_raw, sem_mode_t'($urandom_range(3)));
				end else if ($urandom_range(1) == 0) begin
					if ($urandom_range(1) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
					set_mode(sem_mode_t'($urandom_range(3)));
				end
				n = eff_width * eff_height;
				if ($urandom_range(4) == 0) n = $urandom_range(1, n - 1);
				repeat (n) send_pixel(random_pixel());
				sent += n;
			end
		end
		wait_drained();

		if (failures == 0 && pending_results == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_grad.sv
rtl/sobel_edge_magnitude_3x3.sv
tb/sobel_edge_magnitude_3x3_checker.sv
tb/sobel_edge_magnitude_3x3_test.sv
